FILE: rtl/dcf_pkg.sv
// Shared constants, step codes and beat type for the display command framer.
`timescale 1ns / 1ps
`default_nettype none

package dcf_pkg;

   localparam int unsigned BYTE_W         = 8;
   localparam int unsigned LEN_W          = 11;
   localparam int unsigned TOTAL_W        = 16;
   localparam int unsigned MAX_PAYLOAD    = 1024;
   localparam int unsigned FRAME_OVERHEAD = 9;

   localparam logic [BYTE_W-1:0] HEAD_BYTE  = 8'hA5;
   localparam logic [BYTE_W-1:0] TAIL_BYTE0 = 8'hCC;
   localparam logic [BYTE_W-1:0] TAIL_BYTE1 = 8'h33;
   localparam logic [BYTE_W-1:0] TAIL_BYTE2 = 8'hC3;
   localparam logic [BYTE_W-1:0] TAIL_BYTE3 = 8'h3C;

   typedef enum logic [3:0] {
      STEP_HEAD,
      STEP_LEN_HI,
      STEP_LEN_LO,
      STEP_CMD,
      STEP_DATA,
      STEP_TAIL0,
      STEP_TAIL1,
      STEP_TAIL2,
      STEP_TAIL3,
      STEP_SUM
   } step_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              end_of_frame;
      logic              last_of_item;
   } beat_type;

endpackage

`default_nettype wire

FILE: rtl/dcf_if.sv
// Request and response channel interfaces of the display command framer.
`timescale 1ns / 1ps
`default_nettype none

interface dcf_req_if;
   logic                       valid;
   logic                       ready;
   logic                       start_frame;
   logic [dcf_pkg::BYTE_W-1:0] cmd;
   logic [dcf_pkg::LEN_W-1:0]  payload_len;
   logic [dcf_pkg::BYTE_W-1:0] data;

   modport source (output valid, start_frame, cmd, payload_len, data, input ready);
   modport sink   (input valid, start_frame, cmd, payload_len, data, output ready);
endinterface

interface dcf_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [dcf_pkg::BYTE_W-1:0] out_byte;
   logic                       end_of_frame;
   logic                       last_of_item;

   modport source (output valid, out_byte, end_of_frame, last_of_item, input ready);
   modport sink   (input valid, out_byte, end_of_frame, last_of_item, output ready);
endinterface

`default_nettype wire

FILE: rtl/dcf_seq.sv
// Item register and byte sequencer: holds one request and walks its frame bytes.
`timescale 1ns / 1ps
`default_nettype none

module dcf_seq (
   input  wire logic               clock,
   input  wire logic               reset,
   dcf_req_if.sink                 req_bus,
   output logic                    beat_valid,
   output dcf_pkg::beat_type       beat,
   input  wire logic               beat_ready
);

   logic                               busy_ff, busy_in;
   dcf_pkg::step_type                  step_ff, step_in;
   logic [dcf_pkg::LEN_W-1:0]          bytes_left_ff, bytes_left_in;
   logic [dcf_pkg::BYTE_W-1:0]         xor_ff, xor_in;
   logic                               tail_ff, tail_in;
   logic                               has_data_ff, has_data_in;
   logic [dcf_pkg::BYTE_W-1:0]         cmd_ff, cmd_in;
   logic [dcf_pkg::BYTE_W-1:0]         data_ff, data_in;
   logic [dcf_pkg::TOTAL_W-1:0]        total_ff, total_in;

   logic                               advance;
   logic                               item_done;
   logic                               accept;
   logic                               drop;
   logic                               load;
   logic [dcf_pkg::LEN_W-1:0]          plen_sat;

   assign advance   = busy_ff && beat_ready;
   assign item_done = advance && beat.last_of_item;
   assign req_bus.ready = !busy_ff || item_done;
   assign accept    = req_bus.valid && req_bus.ready;
   assign drop      = !req_bus.start_frame && (bytes_left_ff == '0);
   assign load      = accept && !drop;

   always_comb begin
      if (32'(req_bus.payload_len) > dcf_pkg::MAX_PAYLOAD) begin
         plen_sat = dcf_pkg::LEN_W'(dcf_pkg::MAX_PAYLOAD);
      end else begin
         plen_sat = req_bus.payload_len;
      end
   end

   // item fields captured on load (an accepted beat that is not dropped)
   always_comb begin
      cmd_in        = req_bus.cmd;
      data_in       = req_bus.data;
      total_in      = dcf_pkg::TOTAL_W'(plen_sat) + dcf_pkg::TOTAL_W'(dcf_pkg::FRAME_OVERHEAD);
      has_data_in   = (plen_sat != '0);
      if (req_bus.start_frame) begin
         bytes_left_in = (plen_sat == '0) ? '0 : plen_sat - 1'b1;
         tail_in       = (plen_sat <= dcf_pkg::LEN_W'(1));
      end else begin
         bytes_left_in = bytes_left_ff - 1'b1;
         tail_in       = (bytes_left_ff == dcf_pkg::LEN_W'(1));
      end
   end

   // next step
   always_comb begin
      step_in = step_ff;
      busy_in = busy_ff;
      if (advance) begin
         case (step_ff)
            dcf_pkg::STEP_HEAD:   step_in = dcf_pkg::STEP_LEN_HI;
            dcf_pkg::STEP_LEN_HI: step_in = dcf_pkg::STEP_LEN_LO;
            dcf_pkg::STEP_LEN_LO: step_in = dcf_pkg::STEP_CMD;
            dcf_pkg::STEP_CMD:    step_in = has_data_ff ? dcf_pkg::STEP_DATA
                                                        : dcf_pkg::STEP_TAIL0;
            dcf_pkg::STEP_DATA: begin
               if (tail_ff) begin
                  step_in = dcf_pkg::STEP_TAIL0;
               end else begin
                  busy_in = 1'b0;
               end
            end
            dcf_pkg::STEP_TAIL0:  step_in = dcf_pkg::STEP_TAIL1;
            dcf_pkg::STEP_TAIL1:  step_in = dcf_pkg::STEP_TAIL2;
            dcf_pkg::STEP_TAIL2:  step_in = dcf_pkg::STEP_TAIL3;
            dcf_pkg::STEP_TAIL3:  step_in = dcf_pkg::STEP_SUM;
            dcf_pkg::STEP_SUM:    busy_in = 1'b0;
            default:              busy_in = 1'b0;
         endcase
      end
      if (accept) begin
         if (req_bus.start_frame) begin
            step_in = dcf_pkg::STEP_HEAD;
            busy_in = 1'b1;
         end else if (!drop) begin
            step_in = dcf_pkg::STEP_DATA;
            busy_in = 1'b1;
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   // beat contents
   always_comb begin
      beat_valid        = busy_ff;
      beat.end_of_frame = 1'b0;
      beat.last_of_item = 1'b0;
      case (step_ff)
         dcf_pkg::STEP_HEAD:   beat.out_byte = dcf_pkg::HEAD_BYTE;
         dcf_pkg::STEP_LEN_HI: beat.out_byte = total_ff[dcf_pkg::TOTAL_W-1 -: dcf_pkg::BYTE_W];
         dcf_pkg::STEP_LEN_LO: beat.out_byte = total_ff[dcf_pkg::BYTE_W-1:0];
         dcf_pkg::STEP_CMD:    beat.out_byte = cmd_ff;
         dcf_pkg::STEP_DATA: begin
            beat.out_byte     = data_ff;
            beat.last_of_item = !tail_ff;
         end
         dcf_pkg::STEP_TAIL0:  beat.out_byte = dcf_pkg::TAIL_BYTE0;
         dcf_pkg::STEP_TAIL1:  beat.out_byte = dcf_pkg::TAIL_BYTE1;
         dcf_pkg::STEP_TAIL2:  beat.out_byte = dcf_pkg::TAIL_BYTE2;
         dcf_pkg::STEP_TAIL3:  beat.out_byte = dcf_pkg::TAIL_BYTE3;
         dcf_pkg::STEP_SUM: begin
            beat.out_byte     = xor_ff;
            beat.end_of_frame = 1'b1;
            beat.last_of_item = 1'b1;
         end
         default:              beat.out_byte = '0;
      endcase
   end

   // running checksum over emitted bytes
   always_comb begin
      xor_in = xor_ff;
      if (advance) begin
         case (step_ff)
            dcf_pkg::STEP_HEAD: xor_in = dcf_pkg::HEAD_BYTE;
            dcf_pkg::STEP_SUM:  xor_in = '0;
            default:            xor_in = xor_ff ^ beat.out_byte;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         step_ff       <= dcf_pkg::STEP_HEAD;
         bytes_left_ff <= '0;
         xor_ff        <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         xor_ff  <= xor_in;
         if (load) begin
            bytes_left_ff <= bytes_left_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tail_ff     <= tail_in;
         has_data_ff <= has_data_in;
         cmd_ff      <= cmd_in;
         data_ff     <= data_in;
         total_ff    <= total_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/dcf_out.sv
// Response register: holds one frame byte until the sink takes it.
`timescale 1ns / 1ps
`default_nettype none

module dcf_out (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               beat_valid,
   input  wire dcf_pkg::beat_type  beat,
   output logic                    beat_ready,
   dcf_rsp_if.source               rsp_bus
);

   logic              valid_ff;
   logic              valid_in;
   dcf_pkg::beat_type beat_ff;

   assign beat_ready = !valid_ff || rsp_bus.ready;
   assign valid_in   = beat_ready ? beat_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (beat_ready && beat_valid) begin
         beat_ff <= beat;
      end
   end

   assign rsp_bus.valid        = valid_ff;
   assign rsp_bus.out_byte     = beat_ff.out_byte;
   assign rsp_bus.end_of_frame = beat_ff.end_of_frame;
   assign rsp_bus.last_of_item = beat_ff.last_of_item;

endmodule

`default_nettype wire

FILE: rtl/display_command_framer.sv
// Display command framer: builds A5 / length / command / payload / tail / XOR frames.
// Each request beat is held in an item register and turned into response beats, one
// frame byte per cycle while the response sink is ready, through a single response
// register. A payload beat gives one byte, so payload streams at one beat per cycle
// while the sink is ready. A start beat gives 5 bytes (header and first byte), 9 for
// an empty frame, and 10 when its only payload byte closes the frame with the tail and
// checksum. A payload beat that closes the frame gives 6. A payload beat with no frame
// open is taken and gives nothing. The first response beat passes the sequencer state
// registers and then the response register after the request beat is accepted.
`timescale 1ns / 1ps
`default_nettype none

module display_command_framer (
   input  wire logic  clock,
   input  wire logic  reset,
   dcf_req_if.sink    req_bus,
   dcf_rsp_if.source  rsp_bus
);

   logic              beat_valid;
   logic              beat_ready;
   dcf_pkg::beat_type beat;

   dcf_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .beat_valid (beat_valid),
      .beat       (beat),
      .beat_ready (beat_ready)
   );

   dcf_out u_out (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (beat_valid),
      .beat       (beat),
      .beat_ready (beat_ready),
      .rsp_bus    (rsp_bus)
   );

endmodule

`default_nettype wire
